// ----- hdl/smv_pkg.sv -----
// smv_pkg: shared types, constants and exp helpers for the softmax vector unit.
// No dependencies.
package smv_pkg;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               is_last;
    } t_in_item;

    typedef struct packed {
        logic [15:0] probability;
        logic [5:0]  position;
        logic        last_of_run;
        logic        truncated;
    } t_out_item;

    // job handed from front to back: element count, drop flag and maximum sample
    typedef struct packed {
        logic [6:0]  count;
        logic        trunc;
        logic [15:0] vmax;
    } t_job;

    localparam logic [17:0] LOG2E_Q16 = 18'd94548;

    // 2^-(2^(k-8)) in Q0.16
    function automatic logic [15:0] frac_coef(input logic [2:0] k);
        logic [15:0] c;
        case (k)
            3'd0: c = 16'd65359;
            3'd1: c = 16'd65182;
            3'd2: c = 16'd64830;
            3'd3: c = 16'd64132;
            3'd4: c = 16'd62757;
            3'd5: c = 16'd60097;
            3'd6: c = 16'd55109;
            default: c = 16'd46341;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/smv_ram.sv -----
// smv_ram: generic single write, single read RAM with registered read.
// No dependencies.
module smv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hdl/smv_back.sv -----
// smv_back: exp and sum pass, then per-element division pass.
// Depends on smv_pkg; reads the element RAM and writes and reads the exp RAM of the top level.
module smv_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  smv_pkg::t_job     i_job,
    output logic              o_job_take,
    output logic [5:0]        o_raddr,
    input  logic [15:0]       i_elem,
    output logic              o_exp_we,
    output logic [5:0]        o_exp_addr,
    output logic [16:0]       o_exp_wdata,
    input  logic [16:0]       i_exp_rdata,
    output logic              o_strobe,
    output smv_pkg::t_out_item o_result
);
    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_EXP = 4'd2, S_FR = 4'd3,
                           S_SH = 4'd4, S_DRD = 4'd5, S_DWT = 4'd6, S_DIV = 4'd7,
                           S_OUT = 4'd8, S_MUL = 4'd9;

    logic [3:0]  r_st;
    smv_pkg::t_job r_job;
    logic [6:0]  r_idx;
    logic [22:0] r_sum;
    logic [33:0] r_t;
    logic [16:0] r_v;
    logic [3:0]  r_k;
    logic [39:0] r_rem;
    logic [16:0] r_q;
    logic [5:0]  r_bit;
    logic [15:0] r_e;
    logic [32:0] r_prod;

    logic signed [16:0] w_d;
    logic [16:0] w_e_full;
    logic [7:0]  w_f;
    logic [25:0] w_n;

    assign w_d = $signed({r_job.vmax[15], r_job.vmax}) - $signed({i_elem[15], i_elem});
    assign w_e_full = w_d[16] ? 17'd0 : w_d;
    assign w_f = r_t[23:16];
    assign w_n = {16'd0, r_t[33:24]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_job_valid) begin
                    r_job <= i_job; r_idx <= '0; r_sum <= '0; r_st <= S_RD;
                end
                S_RD: r_st <= S_MUL;
                S_MUL: begin
                    r_e <= w_e_full[15:0];
                    r_st <= S_EXP;
                end
                S_EXP: begin
                    r_t <= {16'd0, r_e} * {16'd0, smv_pkg::LOG2E_Q16} + 34'd32768;
                    r_v <= 17'd65536; r_k <= '0; r_st <= S_FR;
                end
                S_FR: begin
                    if (r_k[3]) r_st <= S_SH;
                    else begin
                        if (w_f[r_k[2:0]]) r_v <= 17'((({16'd0, r_v} *
                            {17'd0, smv_pkg::frac_coef(r_k[2:0])}) + 33'd32768) >> 16);
                        r_k <= r_k + 4'd1;
                    end
                end
                S_SH: begin
                    if (w_n > 26'd16) r_v <= '0; else r_v <= r_v >> w_n[4:0];
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    r_sum <= r_sum + {6'd0, r_v};
                    r_idx <= r_idx + 7'd1;
                    if (r_idx + 7'd1 == r_job.count) begin
                        r_idx <= '0; r_st <= S_DRD;
                    end else r_st <= S_RD;
                end
                S_DRD: r_st <= S_DWT;
                S_DWT: begin
                    // dividend = exp*65536 + sum/2, restoring division, 40 bits
                    r_rem <= 40'({i_exp_rdata, 16'd0} + {18'd0, r_sum[22:1]});
                    r_q <= '0; r_bit <= 6'd40; r_st <= S_DIV;
                end
                S_DIV: begin
                    // shift dividend out of the top of r_rem into partial remainder r_prod; quotient bits go to r_q
                    if (r_bit == 6'd0) begin
                        o_strobe <= 1'b1;
                        o_result.probability <= (|r_q[16]) ? 16'hFFFF : r_q[15:0];
                        o_result.position <= r_idx[5:0];
                        o_result.last_of_run <= (r_idx + 7'd1 == r_job.count);
                        o_result.truncated <= r_job.trunc;
                        r_idx <= r_idx + 7'd1;
                        r_st <= (r_idx + 7'd1 == r_job.count) ? S_IDLE : S_DRD;
                    end else begin
                        r_bit <= r_bit - 6'd1;
                        r_rem <= r_rem << 1;
                        if ({r_prod[31:0], r_rem[39]} >= {10'd0, r_sum}) begin
                            r_prod <= 33'({r_prod[31:0], r_rem[39]} - {10'd0, r_sum});
                            r_q <= {r_q[15:0], 1'b1};
                        end else begin
                            r_prod <= {r_prod[31:0], r_rem[39]};
                            r_q <= {r_q[15:0], 1'b0};
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
            if (r_st == S_DWT) r_prod <= '0;
        end
    end

    assign o_job_take  = (r_st == S_IDLE) && i_job_valid;
    assign o_raddr     = r_idx[5:0];
    assign o_exp_we    = (r_st == S_OUT);
    assign o_exp_addr  = r_idx[5:0];
    assign o_exp_wdata = r_v;
endmodule

// ----- hdl/softmax_vector_unit_top.sv -----
// softmax_vector_unit_top: front (store, max) plus back (exp, divide) via a one-job queue.
// Depends on smv_pkg, smv_ram, smv_back.
//  channel | ports                  | handshake
//  input   | i_start, i_item        | accepted when i_start && !o_busy
//  result  | o_strobe, o_result     | one cycle per result, no back-pressure
// Elements are stored as they are accepted. The last element queues a job; the back
// makes an exp and sum pass over the elements, followed by a division pass with the
// 40-step restoring divider. Busy stays high while a job is queued or the back
// is still working. Synchronous reset clears control; stores need no clearing.
module softmax_vector_unit_top #(
    parameter int MAX_LEN = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  smv_pkg::t_in_item  i_item,
    output logic               o_busy,
    output logic               o_strobe,
    output smv_pkg::t_out_item o_result
);
    logic [6:0]  r_count;
    logic signed [15:0] r_max;
    logic        r_trunc;
    logic        r_qv;
    smv_pkg::t_job r_q;
    logic        w_take, w_acc, w_store;
    logic [5:0]  w_raddr, w_eaddr;
    logic [15:0] w_elem;
    logic        w_ewe;
    logic [16:0] w_ewd, w_erd;
    logic        r_bbusy;

    assign w_acc   = i_start && !o_busy;
    assign w_store = w_acc && (r_count < 7'(MAX_LEN));
    assign o_busy  = r_qv || r_bbusy;

    // front: store elements, track max, queue a job on last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0; r_max <= 16'sh8000; r_trunc <= 1'b0; r_qv <= 1'b0;
            r_bbusy <= 1'b0;
        end else begin
            if (w_take) begin r_qv <= 1'b0; r_bbusy <= 1'b1; end
            if (o_strobe && o_result.last_of_run) r_bbusy <= 1'b0;
            if (w_acc) begin
                if (w_store) begin
                    r_count <= r_count + 7'd1;
                    if (i_item.sample > r_max) r_max <= i_item.sample;
                end else r_trunc <= 1'b1;
                if (i_item.is_last) begin
                    r_qv <= 1'b1;
                    r_q.count <= w_store ? r_count + 7'd1 : r_count;
                    r_q.trunc <= r_trunc || !w_store;
                    r_q.vmax <= (w_store && i_item.sample > r_max) ? i_item.sample : r_max;
                    r_count <= '0; r_max <= 16'sh8000; r_trunc <= 1'b0;
                end
            end
        end
    end

    smv_ram #(.WIDTH(16), .DEPTH(64)) u_elem (
        .i_clk(i_clk), .i_we(w_store), .i_waddr(r_count[5:0]), .i_wdata(i_item.sample),
        .i_raddr(r_bbusy ? w_raddr : 6'd0), .o_rdata(w_elem));

    smv_ram #(.WIDTH(17), .DEPTH(64)) u_exp (
        .i_clk(i_clk), .i_we(w_ewe), .i_waddr(w_eaddr), .i_wdata(w_ewd),
        .i_raddr(w_eaddr), .o_rdata(w_erd));

    smv_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(r_qv), .i_job(r_q),
        .o_job_take(w_take), .o_raddr(w_raddr), .i_elem(w_elem),
        .o_exp_we(w_ewe), .o_exp_addr(w_eaddr), .o_exp_wdata(w_ewd),
        .i_exp_rdata(w_erd), .o_strobe(o_strobe), .o_result(o_result));

    a_no_store_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !w_store) else $error("store while busy");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 7'(MAX_LEN)) else $error("count overrun");
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_bbusy)) else $error("result while idle");
endmodule
